// ===== sv/ptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID turn controller package
// Shared widths, register indexes, reset values and the config bundle.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int GAIN_W     = 24;
    localparam int ERR_W      = 9;
    localparam int DIFF_W     = 10;
    localparam int TURN_W     = 8;
    localparam int LIMIT_W    = 7;
    localparam int P_W        = ERR_W + GAIN_W + 1;
    localparam int D_W        = DIFF_W + GAIN_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PGAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DGAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd4;

    localparam logic [SAMPLE_W-1:0] RST_TARGET = 8'd128;
    localparam logic [GAIN_W-1:0]   RST_PGAIN  = 24'd117965;
    localparam logic [GAIN_W-1:0]   RST_IGAIN  = 24'd1950;
    localparam logic [GAIN_W-1:0]   RST_DGAIN  = 24'd1784218;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 7'd100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] target;
        logic [GAIN_W-1:0]   pgain;
        logic [GAIN_W-1:0]   igain;
        logic [GAIN_W-1:0]   dgain;
        logic [LIMIT_W-1:0]  limit;
    } t_cfg;

endpackage

// ===== sv/ptc_err_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID turn controller error stage
// Forms the error, keeps the saturating error sum, the previous error and the error difference.
// ----------------------------------------------------------------------------
module ptc_err_stage #(
    parameter int SUM_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [ptc_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [ptc_pkg::SAMPLE_W-1:0]        i_target,
    output logic signed [ptc_pkg::ERR_W-1:0]    o_err,
    output logic signed [ptc_pkg::DIFF_W-1:0]   o_diff,
    output logic signed [SUM_WIDTH-1:0]         o_sum
);
    import ptc_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [ERR_W-1:0]     err;
    logic signed [SUM_WIDTH:0]   sum_ext;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic signed [DIFF_W-1:0]    n_diff;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [ERR_W-1:0]     r_last;
    logic signed [DIFF_W-1:0]    r_diff;

    always_comb begin
        err     = $signed({1'b0, i_target}) - $signed({1'b0, i_sample});
        sum_ext = {r_sum[SUM_WIDTH-1], r_sum}
                + {{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            n_sum = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = sum_ext[SUM_WIDTH-1:0];
        end
        n_diff = {err[ERR_W-1], err} - {r_last[ERR_W-1], r_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_load) begin
            r_sum  <= n_sum;
            r_last <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= n_diff;
        end
    end

    assign o_err  = r_last;
    assign o_diff = r_diff;
    assign o_sum  = r_sum;

endmodule

// ===== sv/ptc_mul_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID turn controller multiply stage
// Gain products; the integral product is split into high and low halves.
// ----------------------------------------------------------------------------
module ptc_mul_stage #(
    parameter int SUM_WIDTH = 24
) (
    input  logic                                             i_clk,
    input  logic                                             i_load,
    input  ptc_pkg::t_cfg                                    i_cfg,
    input  logic signed [ptc_pkg::ERR_W-1:0]                 i_err,
    input  logic signed [ptc_pkg::DIFF_W-1:0]                i_diff,
    input  logic signed [SUM_WIDTH-1:0]                      i_sum,
    output logic signed [ptc_pkg::P_W-1:0]                   o_p,
    output logic signed [ptc_pkg::D_W-1:0]                   o_d,
    output logic signed [SUM_WIDTH-SUM_WIDTH/2+ptc_pkg::GAIN_W:0] o_ihi,
    output logic [SUM_WIDTH/2+ptc_pkg::GAIN_W-1:0]           o_ilo
);
    import ptc_pkg::*;

    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int IHI_W = HI_W + GAIN_W + 1;
    localparam int ILO_W = LO_W + GAIN_W;

    logic signed [GAIN_W:0]  pg;
    logic signed [GAIN_W:0]  dg;
    logic signed [GAIN_W:0]  ig;
    logic signed [HI_W-1:0]  sum_hi;
    logic [LO_W-1:0]         sum_lo;
    logic signed [P_W-1:0]   n_p;
    logic signed [D_W-1:0]   n_d;
    logic signed [IHI_W-1:0] n_ihi;
    logic [ILO_W-1:0]        n_ilo;
    logic signed [P_W-1:0]   r_p;
    logic signed [D_W-1:0]   r_d;
    logic signed [IHI_W-1:0] r_ihi;
    logic [ILO_W-1:0]        r_ilo;

    always_comb begin
        pg     = $signed({1'b0, i_cfg.pgain});
        dg     = $signed({1'b0, i_cfg.dgain});
        ig     = $signed({1'b0, i_cfg.igain});
        sum_hi = i_sum[SUM_WIDTH-1:LO_W];
        sum_lo = i_sum[LO_W-1:0];
        n_p    = P_W'(i_err) * P_W'(pg);
        n_d    = D_W'(i_diff) * D_W'(dg);
        n_ihi  = IHI_W'(sum_hi) * IHI_W'(ig);
        n_ilo  = ILO_W'(sum_lo) * ILO_W'(i_cfg.igain);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p   <= n_p;
            r_d   <= n_d;
            r_ihi <= n_ihi;
            r_ilo <= n_ilo;
        end
    end

    assign o_p   = r_p;
    assign o_d   = r_d;
    assign o_ihi = r_ihi;
    assign o_ilo = r_ilo;

endmodule

// ===== sv/ptc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID turn controller output stage
// Sums the terms, truncates toward zero, negates and clamps the turn.
// ----------------------------------------------------------------------------
module ptc_out_stage #(
    parameter int SUM_WIDTH      = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_load_sum,
    input  logic                                             i_load_turn,
    input  logic [ptc_pkg::LIMIT_W-1:0]                      i_limit,
    input  logic signed [ptc_pkg::P_W-1:0]                   i_p,
    input  logic signed [ptc_pkg::D_W-1:0]                   i_d,
    input  logic signed [SUM_WIDTH-SUM_WIDTH/2+ptc_pkg::GAIN_W:0] i_ihi,
    input  logic [SUM_WIDTH/2+ptc_pkg::GAIN_W-1:0]           i_ilo,
    output logic signed [ptc_pkg::TURN_W-1:0]                o_turn
);
    import ptc_pkg::*;

    localparam int LO_W = SUM_WIDTH / 2;
    localparam int U_W  = SUM_WIDTH + GAIN_W + 3;

    logic signed [U_W-1:0]    n_u;
    logic signed [U_W-1:0]    r_u;
    logic signed [U_W-1:0]    quo;
    logic signed [U_W-1:0]    quo_t;
    logic signed [U_W-1:0]    lim_w;
    logic signed [TURN_W-1:0] lim_t;
    logic                     frac_nz;
    logic signed [TURN_W-1:0] n_turn;
    logic signed [TURN_W-1:0] r_turn;

    always_comb begin
        n_u = U_W'(i_p) + U_W'(i_d) + (U_W'(i_ihi) <<< LO_W) + $signed(U_W'(i_ilo));
    end

    // truncate toward zero: round the floor up for negative values with a fraction
    always_comb begin
        quo     = r_u >>> GAIN_FRAC_BITS;
        frac_nz = |r_u[GAIN_FRAC_BITS-1:0];
        quo_t   = quo + $signed(U_W'(r_u[U_W-1] & frac_nz));
        lim_w   = $signed(U_W'(i_limit));
        lim_t   = $signed({1'b0, i_limit});
        if (quo_t > lim_w) begin
            n_turn = -lim_t;
        end else if (quo_t < -lim_w) begin
            n_turn = lim_t;
        end else begin
            n_turn = $signed(-quo_t[TURN_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_sum) begin
            r_u <= n_u;
        end
        if (i_load_turn) begin
            r_turn <= n_turn;
        end
    end

    assign o_turn = r_turn;

endmodule

// ===== sv/pid_turn_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID turn controller top
// Pipeline: an accepted word moves through stage valids r_v1 to r_v5; o_valid is r_v5.
// Throughput: one word per cycle; input stalls only on output back-pressure
// through the five pipeline stages.
// Reset: clears error sum, previous error and stage valids; config registers
// return to their defaults.
// ----------------------------------------------------------------------------
module pid_turn_controller_top #(
    parameter int SUM_WIDTH      = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [ptc_pkg::SAMPLE_W-1:0]         i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ptc_pkg::TURN_W-1:0]    o_turn,
    input  logic                                 i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ptc_pkg::*;

    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int IHI_W = HI_W + GAIN_W + 1;
    localparam int ILO_W = LO_W + GAIN_W;

    t_cfg                    r_cfg;
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [SAMPLE_W-1:0]     r_s1_sample;
    logic                    rdy1, rdy2, rdy3, rdy4, rdy5;
    logic signed [ERR_W-1:0]     err;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [SUM_WIDTH-1:0] sum;
    logic signed [P_W-1:0]       pterm;
    logic signed [D_W-1:0]       dterm;
    logic signed [IHI_W-1:0]     ihi;
    logic [ILO_W-1:0]            ilo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= RST_TARGET;
            r_cfg.pgain  <= RST_PGAIN;
            r_cfg.igain  <= RST_IGAIN;
            r_cfg.dgain  <= RST_DGAIN;
            r_cfg.limit  <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET: r_cfg.target <= i_cfg_data[SAMPLE_W-1:0];
                CFG_PGAIN:  r_cfg.pgain  <= i_cfg_data[GAIN_W-1:0];
                CFG_IGAIN:  r_cfg.igain  <= i_cfg_data[GAIN_W-1:0];
                CFG_DGAIN:  r_cfg.dgain  <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT:  r_cfg.limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign rdy5 = !r_v5 || i_ready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_sample <= i_sample;
        end
    end

    ptc_err_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_err (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_v1 && rdy2),
        .i_sample (r_s1_sample),
        .i_target (r_cfg.target),
        .o_err    (err),
        .o_diff   (diff),
        .o_sum    (sum)
    );

    ptc_mul_stage #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_load (r_v2 && rdy3),
        .i_cfg  (r_cfg),
        .i_err  (err),
        .i_diff (diff),
        .i_sum  (sum),
        .o_p    (pterm),
        .o_d    (dterm),
        .o_ihi  (ihi),
        .o_ilo  (ilo)
    );

    ptc_out_stage #(
        .SUM_WIDTH      (SUM_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_load_sum  (r_v3 && rdy4),
        .i_load_turn (r_v4 && rdy5),
        .i_limit     (r_cfg.limit),
        .i_p         (pterm),
        .i_d         (dterm),
        .i_ihi       (ihi),
        .i_ilo       (ilo),
        .o_turn      (o_turn)
    );

    assign o_ready = rdy1;
    assign o_valid = r_v5;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without output back-pressure");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted word lost at first stage");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_turn)))
        else $error("stalled result changed");

endmodule
